@@ sv/trd_pkg.sv @@
// Shared constants, codes and structs of the tile row detiler.
`timescale 1ns / 1ps

package trd_pkg;

	localparam int MAX_WIDTH   = 512;
	localparam int MAX_TILE    = 16;
	localparam int BANK_WORDS  = MAX_WIDTH * MAX_TILE;
	localparam int IDX_W       = $clog2(BANK_WORDS);
	localparam int ADDR_W      = IDX_W + 1;
	localparam int RAM_DEPTH   = 2 * BANK_WORDS;
	localparam int RW_W        = IDX_W + 1;
	localparam int TCNT_W      = (MAX_TILE > 1) ? $clog2(MAX_TILE) : 1;

	localparam int PIX_W       = 32;
	localparam int IW_W        = 10;
	localparam int TW_W        = 5;
	localparam int TH_W        = 5;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 10;

	localparam int QUEUE_DEPTH = 4;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = QPTR_W + 1;

	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_WIDTH  = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TILE_HEIGHT = 2'd2;

	localparam logic [IW_W-1:0] RST_IMAGE_WIDTH = 10'd256;
	localparam logic [TW_W-1:0] RST_TILE_WIDTH  = 5'd1;
	localparam logic [TH_W-1:0] RST_TILE_HEIGHT = 5'd1;

	typedef enum logic [2:0] {
		ST_PIXEL  = 3'd0,
		ST_ACCEPT = 3'd1,
		ST_EMPTY  = 3'd2,
		ST_REJECT = 3'd3,
		ST_LAYOUT = 3'd4
	} status_t;

	typedef struct packed {
		logic [IW_W-1:0] image_width;
		logic [TW_W-1:0] tile_width;
		logic [TH_W-1:0] tile_height;
		logic [RW_W-1:0] row_words;
		logic            layout_ok;
	} layout_t;

	typedef struct packed {
		logic    valid;
		status_t status;
		logic    last;
	} cmd_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             last;
		status_t          status;
	} result_t;

endpackage

@@ sv/tile_row_detiler_core.sv @@
// Top level of the tile row detiler: reorders tile-ordered pixels into raster order.
`timescale 1ns / 1ps

// Pixels arrive tile by tile across one tile row (kind 0) and are written into a
// two-bank line store at y * image_width + x; drain requests (kind 1) read the
// oldest completed tile row back in raster order, one pixel per request, with
// row_last on its final pixel. Every request gets exactly one result, in order.
// Throughput is one request per clock while full is low: the line store has a single
// port that serves one push or one drain read per cycle. A result is registered
// with the store read (read data and cmd_s1) and then written into the result queue,
// and the four-entry queue lets the input keep flowing while results wait for pop.
// Each write to a known configuration register restarts the stream (counters
// and bank flags clear, stored pixels stay) and holds full high while the layout
// unit divides image_width by tile_width one bit per cycle. The configuration port
// is always ready.
module tile_row_detiler_core (
	input  logic                            clk,
	input  logic                            arst_n,
	// request side
	input  logic                            push,
	output logic                            full,
	input  logic                            kind,
	input  logic [trd_pkg::PIX_W-1:0]       pixel_in,
	// result side
	output logic                            empty,
	input  logic                            pop,
	output logic [trd_pkg::PIX_W-1:0]       pixel_out,
	output logic                            row_last,
	output logic [2:0]                      status,
	// configuration writes
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [trd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [trd_pkg::CFG_DATA_W-1:0]  cfg_data
);
	import trd_pkg::*;

	layout_t             layout;
	logic                cfg_busy;
	logic                restart;
	logic                accept;
	logic                q_full;
	logic                ram_we;
	logic [ADDR_W-1:0]   ram_addr;
	logic [PIX_W-1:0]    ram_wdata;
	logic [PIX_W-1:0]    ram_rdata;
	cmd_t                cmd;
	result_t             result;

	assign cfg_ready = 1'b1;

	// hold requests off while the layout check runs or the queue has no room
	assign full   = cfg_busy || q_full;
	assign accept = push && !full;

	trd_layout u_layout (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.layout    (layout),
		.busy      (cfg_busy),
		.restart   (restart)
	);

	trd_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.accept    (accept),
		.kind      (kind),
		.pixel_in  (pixel_in),
		.layout    (layout),
		.restart   (restart),
		.ram_we    (ram_we),
		.ram_addr  (ram_addr),
		.ram_wdata (ram_wdata),
		.cmd       (cmd)
	);

	// two banks of MAX_WIDTH * MAX_TILE pixels; bank select is the address MSB
	trd_ram #(
		.WIDTH (PIX_W),
		.DEPTH (RAM_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (ram_we),
		.addr  (ram_addr),
		.wdata (ram_wdata),
		.rdata (ram_rdata)
	);

	trd_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.ram_rdata (ram_rdata),
		.pop       (pop),
		.q_full    (q_full),
		.empty     (empty),
		.result    (result)
	);

	assign pixel_out = result.pixel;
	assign row_last  = result.last;
	assign status    = result.status;

endmodule

@@ sv/trd_ram.sv @@
// Generic single-port RAM with registered read data.
`timescale 1ns / 1ps

module trd_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[addr] <= wdata;
		end
		rdata <= mem_q[addr];
	end

endmodule

@@ sv/trd_layout.sv @@
// Configuration registers and the serial layout check (width modulo tile width).
`timescale 1ns / 1ps

module trd_layout (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [trd_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [trd_pkg::CFG_DATA_W-1:0]  cfg_data,
	output trd_pkg::layout_t                layout,
	output logic                            busy,
	output logic                            restart
);
	import trd_pkg::*;

	localparam int STEP_W = $clog2(IW_W);
	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(IW_W - 1);
	localparam int PROD_W = IW_W + TH_W;

	logic [IW_W-1:0]   iw_q;
	logic [TW_W-1:0]   tw_q;
	logic [TH_W-1:0]   th_q;
	logic              busy_q;
	logic [STEP_W-1:0] step_q;
	logic [TW_W:0]     rem_q;
	logic              ok_q;
	logic [RW_W-1:0]   row_words_q;

	logic              bit_sel;
	logic [TW_W:0]     rem_shift;
	logic [TW_W:0]     rem_next;
	logic              range_ok;
	logic [PROD_W-1:0] prod;
	logic [RW_W-1:0]   rw_cap;

	assign restart = cfg_valid && (cfg_index == REG_IMAGE_WIDTH
		|| cfg_index == REG_TILE_WIDTH || cfg_index == REG_TILE_HEIGHT);

	// one restoring-division step per cycle, MSB of the width first
	always_comb begin
		bit_sel   = iw_q[LAST_STEP - step_q];
		rem_shift = {rem_q[TW_W-1:0], bit_sel};
		if (rem_shift >= {1'b0, tw_q}) begin
			rem_next = rem_shift - {1'b0, tw_q};
		end else begin
			rem_next = rem_shift;
		end
	end

	always_comb begin
		range_ok = (iw_q != '0) && (iw_q <= IW_W'(MAX_WIDTH))
			&& (tw_q != '0) && (tw_q <= TW_W'(MAX_TILE))
			&& (th_q != '0) && (th_q <= TH_W'(MAX_TILE));
		prod = PROD_W'(iw_q) * PROD_W'(th_q);
		if (prod > PROD_W'(BANK_WORDS)) begin
			rw_cap = RW_W'(BANK_WORDS);
		end else if (prod == '0) begin
			rw_cap = RW_W'(1);
		end else begin
			rw_cap = RW_W'(prod);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iw_q        <= RST_IMAGE_WIDTH;
			tw_q        <= RST_TILE_WIDTH;
			th_q        <= RST_TILE_HEIGHT;
			busy_q      <= 1'b0;
			step_q      <= '0;
			rem_q       <= '0;
			ok_q        <= 1'b1;
			row_words_q <= RW_W'(RST_IMAGE_WIDTH);
		end else if (restart) begin
			unique case (cfg_index)
				REG_IMAGE_WIDTH: iw_q <= cfg_data[IW_W-1:0];
				REG_TILE_WIDTH:  tw_q <= cfg_data[TW_W-1:0];
				REG_TILE_HEIGHT: th_q <= cfg_data[TH_W-1:0];
				default: ;
			endcase
			busy_q <= 1'b1;
			step_q <= '0;
			rem_q  <= '0;
			ok_q   <= 1'b0;
		end else if (busy_q) begin
			rem_q  <= rem_next;
			step_q <= step_q + 1'b1;
			if (step_q == LAST_STEP) begin
				busy_q      <= 1'b0;
				ok_q        <= range_ok && (rem_next == '0);
				row_words_q <= rw_cap;
			end
		end
	end

	assign busy               = busy_q;
	assign layout.image_width = iw_q;
	assign layout.tile_width  = tw_q;
	assign layout.tile_height = th_q;
	assign layout.row_words   = row_words_q;
	assign layout.layout_ok   = ok_q;

endmodule

@@ sv/trd_front.sv @@
// Front end: classify requests, step fill and drain counters, drive the line store port.
`timescale 1ns / 1ps

module trd_front (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        accept,
	input  logic                        kind,
	input  logic [trd_pkg::PIX_W-1:0]   pixel_in,
	input  trd_pkg::layout_t            layout,
	input  logic                        restart,
	output logic                        ram_we,
	output logic [trd_pkg::ADDR_W-1:0]  ram_addr,
	output logic [trd_pkg::PIX_W-1:0]   ram_wdata,
	output trd_pkg::cmd_t               cmd
);
	import trd_pkg::*;

	logic              fill_bank_q;
	logic [TCNT_W-1:0] x_q;
	logic [TCNT_W-1:0] y_q;
	logic [IDX_W-1:0]  y_off_q;
	logic [IW_W-1:0]   col_x_q;
	logic [IDX_W-1:0]  drain_idx_q;
	logic [1:0]        bank_full_q;

	logic              fill_full;
	logic              drain_any;
	logic              dbank;
	logic              x_wrap;
	logic              y_wrap;
	logic              col_wrap;
	logic              drain_last;
	logic [IDX_W-1:0]  faddr;
	logic              push_ok;
	logic              drain_ok;

	always_comb begin
		fill_full  = bank_full_q[fill_bank_q];
		drain_any  = |bank_full_q;
		// with both banks full the fill pointer marks the older one
		dbank      = (&bank_full_q) ? fill_bank_q : ~bank_full_q[0];
		x_wrap     = (TW_W'(x_q) + 1'b1) >= layout.tile_width;
		y_wrap     = (TH_W'(y_q) + 1'b1) >= layout.tile_height;
		col_wrap   = ((IW_W+1)'(col_x_q) + (IW_W+1)'(layout.tile_width))
			>= (IW_W+1)'(layout.image_width);
		drain_last = (RW_W'(drain_idx_q) + 1'b1) >= layout.row_words;
		faddr      = y_off_q + IDX_W'(col_x_q) + IDX_W'(x_q);
		push_ok    = accept && !kind && layout.layout_ok && !fill_full;
		drain_ok   = accept && kind && drain_any;
	end

	always_comb begin
		cmd.valid = accept;
		cmd.last  = drain_ok && drain_last;
		if (!kind) begin
			if (!layout.layout_ok) begin
				cmd.status = ST_LAYOUT;
			end else if (fill_full) begin
				cmd.status = ST_REJECT;
			end else begin
				cmd.status = ST_ACCEPT;
			end
		end else begin
			cmd.status = drain_any ? ST_PIXEL : ST_EMPTY;
		end
		ram_we    = push_ok;
		ram_addr  = kind ? {dbank, drain_idx_q} : {fill_bank_q, faddr};
		ram_wdata = pixel_in;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fill_bank_q <= 1'b0;
			x_q         <= '0;
			y_q         <= '0;
			y_off_q     <= '0;
			col_x_q     <= '0;
			drain_idx_q <= '0;
			bank_full_q <= '0;
		end else if (restart) begin
			fill_bank_q <= 1'b0;
			x_q         <= '0;
			y_q         <= '0;
			y_off_q     <= '0;
			col_x_q     <= '0;
			drain_idx_q <= '0;
			bank_full_q <= '0;
		end else if (push_ok) begin
			if (x_wrap) begin
				x_q <= '0;
				if (y_wrap) begin
					y_q     <= '0;
					y_off_q <= '0;
					if (col_wrap) begin
						col_x_q                  <= '0;
						bank_full_q[fill_bank_q] <= 1'b1;
						fill_bank_q              <= ~fill_bank_q;
					end else begin
						col_x_q <= col_x_q + IW_W'(layout.tile_width);
					end
				end else begin
					y_q     <= y_q + 1'b1;
					y_off_q <= y_off_q + IDX_W'(layout.image_width);
				end
			end else begin
				x_q <= x_q + 1'b1;
			end
		end else if (drain_ok) begin
			if (drain_last) begin
				drain_idx_q        <= '0;
				bank_full_q[dbank] <= 1'b0;
			end else begin
				drain_idx_q <= drain_idx_q + 1'b1;
			end
		end
	end

endmodule

@@ sv/trd_back.sv @@
// Back end: align store read data with its request and queue the results.
`timescale 1ns / 1ps

module trd_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  trd_pkg::cmd_t              cmd,
	input  logic [trd_pkg::PIX_W-1:0]  ram_rdata,
	input  logic                       pop,
	output logic                       q_full,
	output logic                       empty,
	output trd_pkg::result_t           result
);
	import trd_pkg::*;

	cmd_t              cmd_s1;
	result_t           res_in;
	result_t           slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              pop_ok;

	always_comb begin
		res_in.pixel  = (cmd_s1.status == ST_PIXEL) ? ram_rdata : '0;
		res_in.last   = cmd_s1.last;
		res_in.status = cmd_s1.status;
		pop_ok        = pop && (count_q != '0);
		// reserve a slot for the request still in the read stage
		q_full        = (count_q + QCNT_W'(cmd_s1.valid)) >= QCNT_W'(QUEUE_DEPTH);
		empty         = (count_q == '0);
		result        = slot_q[rd_ptr_q];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cmd_s1   <= '0;
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			cmd_s1 <= cmd;
			if (cmd_s1.valid) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop_ok) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			count_q <= count_q + QCNT_W'(cmd_s1.valid) - QCNT_W'(pop_ok);
		end
	end

	always_ff @(posedge clk) begin
		if (cmd_s1.valid) begin
			slot_q[wr_ptr_q] <= res_in;
		end
	end

endmodule
